### hdl/adc_conversion_scheduler_top_assert.svh
// ----------------------------------------------------------------------------
// assertion macros for the conversion scheduler
// clocked on clk_i, quiet while rst_ni is low
// ----------------------------------------------------------------------------
`ifndef ADC_CONVERSION_SCHEDULER_TOP_ASSERT_SVH
`define ADC_CONVERSION_SCHEDULER_TOP_ASSERT_SVH

// same-cycle implication
`define ACS_ASSERT_HOLDS(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ACS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/acs_pkg.sv
// ----------------------------------------------------------------------------
// acs_pkg
// shared types, constants and helpers of the conversion scheduler
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package acs_pkg;

  localparam int TrigSlots  = 8;
  localparam int QueueSlots = 8;

  localparam int TrigIdxW  = (TrigSlots > 1) ? $clog2(TrigSlots) : 1;
  localparam int TrigCntW  = $clog2(TrigSlots + 1);
  localparam int QueueIdxW = $clog2(QueueSlots);

  localparam int OpW       = 3;
  localparam int PinW      = 5;
  localparam int PeriodW   = 16;
  localparam int SampleW   = 10;
  localparam int WideW     = 31;
  localparam int PinCountW = 6;
  localparam int PaddrW    = 3;
  localparam int PdataW    = 32;

  localparam logic [PinCountW-1:0] PinCountReset = 6'd25;

  // register index, taken from paddr[2]
  localparam logic REG_PIN_COUNT = 1'b0;

  // result kinds
  localparam logic KIND_START  = 1'b0;
  localparam logic KIND_REPORT = 1'b1;

  typedef enum logic [OpW-1:0] {
    OP_ADD      = 3'd0,
    OP_REMOVE   = 3'd1,
    OP_REQUEST  = 3'd2,
    OP_TICK     = 3'd3,
    OP_COMPLETE = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD,
    ST_REQ,
    ST_WALK,
    ST_CPL,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic [OpW-1:0]     op;
    logic [PinW-1:0]    pin;
    logic [PeriodW-1:0] period;
    logic [SampleW-1:0] sample;
  } in_t;

  typedef struct packed {
    logic             kind;
    logic [PinW-1:0]  out_pin;
    logic [WideW-1:0] wide_value;
    logic             last;
  } out_t;

  typedef struct packed {
    logic               add;
    logic               walk_start;
    logic               walk_step;
    logic               remove;
    logic [PinW-1:0]    pin;
    logic [PeriodW-1:0] period;
  } trig_ctl_t;

  typedef struct packed {
    logic            walk_end;
    logic            wrap;
    logic [PinW-1:0] wrap_pin;
  } trig_sts_t;

  typedef struct packed {
    logic            push;
    logic            pop;
    logic [PinW-1:0] pin;
  } ring_ctl_t;

  typedef struct packed {
    logic            empty;
    logic [PinW-1:0] pop_pin;
  } ring_sts_t;

  // 10-bit sample spread over 31 bits by replication
  function automatic logic [WideW-1:0] widen(input logic [SampleW-1:0] v);
    return {v, v, v, v[SampleW-1]};
  endfunction

endpackage

`default_nettype wire

### hdl/acs_trig_unit.sv
// ----------------------------------------------------------------------------
// acs_trig_unit
// trigger table with one shared count/compare unit, walked one entry a cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module acs_trig_unit (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire acs_pkg::trig_ctl_t ctl_i,
  output acs_pkg::trig_sts_t      sts_o
);

  logic [acs_pkg::PinW-1:0]    pin_q    [acs_pkg::TrigSlots];
  logic [acs_pkg::PeriodW-1:0] period_q [acs_pkg::TrigSlots];
  logic [acs_pkg::PeriodW-1:0] count_q  [acs_pkg::TrigSlots];

  logic [acs_pkg::TrigCntW-1:0] used_q, idx_q, keep_q;

  logic [acs_pkg::TrigIdxW-1:0] rd_idx, wr_idx, add_idx;
  logic                         full, walk_end, step_act, keep_entry, wrap_cnt;
  logic [acs_pkg::PeriodW:0]    count_inc;
  logic [acs_pkg::PeriodW-1:0]  count_new;

  assign rd_idx  = idx_q[acs_pkg::TrigIdxW-1:0];
  assign wr_idx  = keep_q[acs_pkg::TrigIdxW-1:0];
  assign add_idx = used_q[acs_pkg::TrigIdxW-1:0];

  assign full       = (used_q == acs_pkg::TrigCntW'(acs_pkg::TrigSlots));
  assign walk_end   = (idx_q >= used_q);
  assign step_act   = ctl_i.walk_step && !walk_end;
  assign keep_entry = (pin_q[rd_idx] != ctl_i.pin);

  // shared incrementer and period compare
  assign count_inc = {1'b0, count_q[rd_idx]} + 1'b1;
  assign wrap_cnt  = (count_inc >= {1'b0, period_q[rd_idx]});
  assign count_new = wrap_cnt ? '0 : count_inc[acs_pkg::PeriodW-1:0];

  assign sts_o.walk_end = walk_end;
  assign sts_o.wrap     = !walk_end && !ctl_i.remove && wrap_cnt;
  assign sts_o.wrap_pin = pin_q[rd_idx];

  // table payload
  always_ff @(posedge clk_i) begin
    if (ctl_i.add && !full) begin
      pin_q[add_idx]    <= ctl_i.pin;
      period_q[add_idx] <= ctl_i.period;
      count_q[add_idx]  <= '0;
    end
    if (step_act) begin
      if (ctl_i.remove) begin
        if (keep_entry) begin
          pin_q[wr_idx]    <= pin_q[rd_idx];
          period_q[wr_idx] <= period_q[rd_idx];
          count_q[wr_idx]  <= count_q[rd_idx];
        end
      end else begin
        count_q[rd_idx] <= count_new;
      end
    end
  end

  // fill level and walk pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
      idx_q  <= '0;
      keep_q <= '0;
    end else begin
      if (ctl_i.add && !full) begin
        used_q <= used_q + 1'b1;
      end
      if (ctl_i.walk_start) begin
        idx_q  <= '0;
        keep_q <= '0;
      end else if (step_act) begin
        idx_q <= idx_q + 1'b1;
        if (ctl_i.remove && keep_entry) begin
          keep_q <= keep_q + 1'b1;
        end
      end else if (ctl_i.walk_step && ctl_i.remove) begin
        used_q <= keep_q;
      end
    end
  end

endmodule

`default_nettype wire

### hdl/acs_req_ring.sv
// ----------------------------------------------------------------------------
// acs_req_ring
// ring of pending pin requests, one slot kept free to tell full from empty
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module acs_req_ring (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire acs_pkg::ring_ctl_t ctl_i,
  output acs_pkg::ring_sts_t      sts_o
);

  localparam logic [acs_pkg::QueueIdxW-1:0] LastIdx =
    acs_pkg::QueueIdxW'(acs_pkg::QueueSlots - 1);

  logic [acs_pkg::PinW-1:0]      ring_q [acs_pkg::QueueSlots];
  logic [acs_pkg::QueueIdxW-1:0] head_q, tail_q, head_nx, tail_nx;
  logic                          full, empty;

  assign head_nx = (head_q == LastIdx) ? '0 : head_q + 1'b1;
  assign tail_nx = (tail_q == LastIdx) ? '0 : tail_q + 1'b1;
  assign full    = (head_nx == tail_q);
  assign empty   = (head_q == tail_q);

  assign sts_o.empty   = empty;
  assign sts_o.pop_pin = ring_q[tail_nx];

  always_ff @(posedge clk_i) begin
    if (ctl_i.push && !full) begin
      ring_q[head_nx] <= ctl_i.pin;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
    end else begin
      if (ctl_i.push && !full) begin
        head_q <= head_nx;
      end
      if (ctl_i.pop && !empty) begin
        tail_q <= tail_nx;
      end
    end
  end

endmodule

`default_nettype wire

### hdl/adc_conversion_scheduler_top.sv
// ----------------------------------------------------------------------------
// adc_conversion_scheduler_top
// conversion scheduler for one converter: trigger table, request ring, runner
// ----------------------------------------------------------------------------
// The block takes one request at a time and is not ready until it has
// finished it. An add passes through ST_ADD, a request through ST_REQ and a
// completion through ST_CPL. A remove or a tick walks the trigger table in
// ST_WALK: one count/compare unit visits the table, at most 8 triggers, one
// entry per cycle. A request or tick that starts a conversion, and a
// completion that starts a queued pin, go on to ST_EMIT for the start. Results
// leave through a one-deep output register, so the next request is taken
// while a finished result still waits; a result that meets a full output
// register holds the sequencer until it drains. A tick gives at most one
// start result, a completion a sample report and possibly a start for the
// next queued pin. pin_count sits at byte address 0 of the register port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "adc_conversion_scheduler_top_assert.svh"

module adc_conversion_scheduler_top (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // request channel
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire acs_pkg::in_t                  in_data_i,
  // result channel
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output acs_pkg::out_t                      out_data_o,
  // register port
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [acs_pkg::PaddrW-1:0]    paddr,
  input  wire logic [acs_pkg::PdataW-1:0]    pwdata,
  output logic [acs_pkg::PdataW-1:0]         prdata,
  output logic                               pready
);

  acs_pkg::state_e state_q, state_d;
  acs_pkg::in_t    in_q;
  acs_pkg::out_t   out_q, out_d;

  logic [acs_pkg::PinCountW-1:0] pin_count_q;
  logic                          busy_q, busy_d;
  logic [acs_pkg::PinW-1:0]      running_pin_q, running_pin_d;
  logic                          pend_start_q, pend_start_d;
  logic                          out_valid_q;
  logic                          load_out;

  acs_pkg::trig_ctl_t trig_ctl;
  acs_pkg::trig_sts_t trig_sts;
  acs_pkg::ring_ctl_t ring_ctl;
  acs_pkg::ring_sts_t ring_sts;

  logic                     slot_free;
  logic                     req_fire, req_ok, req_start;
  logic [acs_pkg::PinW-1:0] req_pin;
  logic                     cfg_write;

  // --------------------------------------------------------------------------
  // register port: single register, no wait states
  // --------------------------------------------------------------------------
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready
                     && (paddr[2] == acs_pkg::REG_PIN_COUNT);

  always_comb begin
    prdata = '0;
    if (paddr[2] == acs_pkg::REG_PIN_COUNT) begin
      prdata = acs_pkg::PdataW'(pin_count_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pin_count_q <= acs_pkg::PinCountReset;
    end else if (cfg_write) begin
      pin_count_q <= pwdata[acs_pkg::PinCountW-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // datapath units
  // --------------------------------------------------------------------------
  acs_trig_unit u_trig (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (trig_ctl),
    .sts_o  (trig_sts)
  );

  acs_req_ring u_ring (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ring_ctl),
    .sts_o  (ring_sts)
  );

  // --------------------------------------------------------------------------
  // pin request: from a request op or from a trigger wrap during a tick walk
  // --------------------------------------------------------------------------
  assign req_fire  = (state_q == acs_pkg::ST_REQ)
                     || ((state_q == acs_pkg::ST_WALK) && trig_sts.wrap);
  assign req_pin   = (state_q == acs_pkg::ST_WALK) ? trig_sts.wrap_pin : in_q.pin;
  assign req_ok    = req_fire && ({1'b0, req_pin} < pin_count_q);
  // converter idle: start at once, otherwise queue (full ring drops it)
  assign req_start = req_ok && !busy_q;

  // output register accepts a new result when empty or draining
  assign slot_free = !out_valid_q || out_ready_i;

  // --------------------------------------------------------------------------
  // sequencer
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= acs_pkg::ST_IDLE;
      busy_q        <= 1'b0;
      running_pin_q <= '0;
      pend_start_q  <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      busy_q        <= busy_d;
      running_pin_q <= running_pin_d;
      pend_start_q  <= pend_start_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // request and result payloads
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
    if (load_out) begin
      out_q <= out_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    busy_d        = busy_q;
    running_pin_d = running_pin_q;
    pend_start_d  = pend_start_q;
    load_out      = 1'b0;
    out_d         = '0;

    trig_ctl            = '0;
    trig_ctl.pin        = in_q.pin;
    trig_ctl.period     = in_q.period;
    trig_ctl.remove     = (in_q.op == acs_pkg::OP_REMOVE);

    ring_ctl      = '0;
    ring_ctl.pin  = req_pin;
    ring_ctl.push = req_ok && busy_q;

    if (req_start) begin
      busy_d        = 1'b1;
      running_pin_d = req_pin;
    end

    unique case (state_q)
      acs_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          unique case (in_data_i.op) inside
            acs_pkg::OP_ADD: begin
              state_d = acs_pkg::ST_ADD;
            end
            acs_pkg::OP_REMOVE, acs_pkg::OP_TICK: begin
              trig_ctl.walk_start = 1'b1;
              state_d             = acs_pkg::ST_WALK;
            end
            acs_pkg::OP_REQUEST: begin
              state_d = acs_pkg::ST_REQ;
            end
            acs_pkg::OP_COMPLETE: begin
              state_d = acs_pkg::ST_CPL;
            end
            default: begin
              state_d = acs_pkg::ST_IDLE;
            end
          endcase
        end
      end

      acs_pkg::ST_ADD: begin
        // zero period or out-of-range pin adds nothing; full table is ignored
        trig_ctl.add = (in_q.period != '0) && ({1'b0, in_q.pin} < pin_count_q);
        state_d      = acs_pkg::ST_IDLE;
      end

      acs_pkg::ST_REQ: begin
        state_d = req_start ? acs_pkg::ST_EMIT : acs_pkg::ST_IDLE;
      end

      acs_pkg::ST_WALK: begin
        trig_ctl.walk_step = 1'b1;
        // only the first wrap of a tick can find the converter idle
        if (req_start) begin
          pend_start_d = 1'b1;
        end
        if (trig_sts.walk_end) begin
          pend_start_d = 1'b0;
          state_d      = pend_start_q ? acs_pkg::ST_EMIT : acs_pkg::ST_IDLE;
        end
      end

      acs_pkg::ST_CPL: begin
        if (!busy_q) begin
          // completion while idle: no report
          state_d = acs_pkg::ST_IDLE;
        end else if (slot_free) begin
          load_out         = 1'b1;
          out_d.kind       = acs_pkg::KIND_REPORT;
          out_d.out_pin    = running_pin_q;
          out_d.wide_value = acs_pkg::widen(in_q.sample);
          out_d.last       = ring_sts.empty;
          if (!ring_sts.empty) begin
            ring_ctl.pop  = 1'b1;
            running_pin_d = ring_sts.pop_pin;
            state_d       = acs_pkg::ST_EMIT;
          end else begin
            busy_d  = 1'b0;
            state_d = acs_pkg::ST_IDLE;
          end
        end
      end

      acs_pkg::ST_EMIT: begin
        // start result for the pin now running, always the final one
        if (slot_free) begin
          load_out         = 1'b1;
          out_d.kind       = acs_pkg::KIND_START;
          out_d.out_pin    = running_pin_q;
          out_d.wide_value = '0;
          out_d.last       = 1'b1;
          state_d          = acs_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = acs_pkg::ST_IDLE;
      end
    endcase
  end

  assign in_ready_o  = (state_q == acs_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  // requests are only queued behind a running conversion
  `ACS_ASSERT_HOLDS(a_idle_ring_empty, !busy_q, ring_sts.empty, "ring holds pins while idle")
  // a start result always belongs to a running conversion
  `ACS_ASSERT_HOLDS(a_emit_busy, state_q == acs_pkg::ST_EMIT, busy_q, "start without conversion")
  // a pending tick start exists only inside a walk
  `ACS_ASSERT_HOLDS(a_pend_in_walk, pend_start_q,
                    busy_q && (state_q == acs_pkg::ST_WALK), "stray pending start")
  // a report with queued work is followed by the next start
  `ACS_ASSERT_NEXT(a_report_then_start,
                   (state_q == acs_pkg::ST_CPL) && busy_q && slot_free && !ring_sts.empty,
                   state_q == acs_pkg::ST_EMIT, "queued pin not started")

endmodule

`default_nettype wire

### dv/adc_conversion_scheduler_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adc_conversion_scheduler_top_tb
// self-checking bench for the conversion scheduler
// ----------------------------------------------------------------------------
// Requests go in through a valid/ready channel and the pin_count register is
// set over the register port. A scoreboard keeps its own copy of the trigger
// table, the request ring and the running conversion. It predicts the start
// and report results of every accepted request and checks them field by field
// against what leaves the result channel. A directed opening covers the corner
// cases. Then random traffic follows under several pin_count settings, with
// random gaps on the request side and random stalls on the result side.
// ----------------------------------------------------------------------------
module adc_conversion_scheduler_top_tb;
  import acs_pkg::*;

  // register port address of pin_count, index in paddr[2]
  localparam logic [PaddrW-1:0] PinCountAddr = {REG_PIN_COUNT, 2'b00};

  // op codes the block has no use for
  localparam logic [OpW-1:0] OpSpareLo = 3'd5;
  localparam logic [OpW-1:0] OpSpareHi = 3'd7;

  // a remove or tick walks the whole table before the block is ready again
  localparam int SettleCycles = 2 * (TrigSlots + 3);

  localparam int RandomPerPhase = 250;
  localparam int IdleSwitchEvery = 60;

  // --------------------------------------------------------------------------
  // scoreboard: predicts the scheduler and holds the results still awaited
  // --------------------------------------------------------------------------
  class sched_scoreboard;
    logic [PinCountW-1:0] pin_limit;
    logic [PinW-1:0]      trig_pin    [TrigSlots];
    logic [PeriodW-1:0]   trig_period [TrigSlots];
    logic [PeriodW-1:0]   trig_count  [TrigSlots];
    int                   trig_used;
    logic [PinW-1:0]      ring        [QueueSlots];
    int                   ring_head;
    int                   ring_tail;
    bit                   busy;
    logic [PinW-1:0]      running_pin;
    out_t                 step_results [$];
    out_t                 awaited_results [$];
    int                   errors;

    function new();
      pin_limit = PinCountReset;
      trig_used = 0;
      ring_head = 0;
      ring_tail = 0;
      busy = 1'b0;
      running_pin = '0;
      errors = 0;
    endfunction

    function void set_pin_limit(logic [PinCountW-1:0] v);
      pin_limit = v;
    endfunction

    function void add_result(logic kind, logic [PinW-1:0] p, logic [WideW-1:0] wv);
      out_t r;
      r.kind = kind;
      r.out_pin = p;
      r.wide_value = wv;
      r.last = 1'b0;
      step_results.push_back(r);
    endfunction

    // start at once when idle, else queue unless the ring is full
    function void launch_or_queue(logic [PinW-1:0] p);
      int nh;
      if ({1'b0, p} >= pin_limit) return;
      if (!busy) begin
        busy = 1'b1;
        running_pin = p;
        add_result(KIND_START, p, '0);
        return;
      end
      nh = (ring_head + 1) % QueueSlots;
      if (nh != ring_tail) begin
        ring[nh] = p;
        ring_head = nh;
      end
    endfunction

    function logic [WideW-1:0] spread_sample(logic [SampleW-1:0] s);
      logic [31:0] v;
      logic [31:0] w;
      v = 32'(s);
      w = (v << 21) | (v << 11) | (v << 1) | (v >> 9);
      return w[WideW-1:0];
    endfunction

    function void note_request(in_t req);
      int j;
      logic [16:0] c;
      step_results.delete();
      case (req.op)
        OP_ADD: begin
          if (req.period != 0 && {1'b0, req.pin} < pin_limit && trig_used < TrigSlots) begin
            trig_pin[trig_used] = req.pin;
            trig_period[trig_used] = req.period;
            trig_count[trig_used] = '0;
            trig_used++;
          end
        end
        OP_REMOVE: begin
          j = 0;
          for (int i = 0; i < trig_used; i++) begin
            if (trig_pin[i] != req.pin) begin
              trig_pin[j] = trig_pin[i];
              trig_period[j] = trig_period[i];
              trig_count[j] = trig_count[i];
              j++;
            end
          end
          trig_used = j;
        end
        OP_REQUEST: launch_or_queue(req.pin);
        OP_TICK: begin
          for (int i = 0; i < trig_used; i++) begin
            c = 17'(trig_count[i]) + 17'd1;
            if (c >= 17'(trig_period[i])) c = '0;
            trig_count[i] = c[PeriodW-1:0];
            if (c == 0) launch_or_queue(trig_pin[i]);
          end
        end
        OP_COMPLETE: begin
          if (busy) begin
            add_result(KIND_REPORT, running_pin, spread_sample(req.sample));
            if (ring_head != ring_tail) begin
              ring_tail = (ring_tail + 1) % QueueSlots;
              running_pin = ring[ring_tail];
              add_result(KIND_START, running_pin, '0);
            end else begin
              busy = 1'b0;
            end
          end
        end
        default: ;
      endcase
      if (step_results.size() > 0) step_results[step_results.size() - 1].last = 1'b1;
      foreach (step_results[i]) awaited_results.push_back(step_results[i]);
    endfunction

    function void check_result(out_t got);
      out_t want;
      if (awaited_results.size() == 0) begin
        $error("unexpected result: kind %0d pin %0d value %0h last %0d",
               got.kind, got.out_pin, got.wide_value, got.last);
        errors++;
        return;
      end
      want = awaited_results.pop_front();
      if (got.kind !== want.kind) begin
        $error("kind: expected %0d, got %0d", want.kind, got.kind);
        errors++;
      end
      if (got.out_pin !== want.out_pin) begin
        $error("out_pin: expected %0d, got %0d", want.out_pin, got.out_pin);
        errors++;
      end
      if (got.wide_value !== want.wide_value) begin
        $error("wide_value: expected %0h, got %0h", want.wide_value, got.wide_value);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0d, got %0d", want.last, got.last);
        errors++;
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // clock, reset and the block
  // --------------------------------------------------------------------------
  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready_o;
  in_t                in_data = '0;
  logic               out_valid_o;
  logic               out_ready = 1'b0;
  out_t               out_data_o;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PaddrW-1:0]  paddr = '0;
  logic [PdataW-1:0]  pwdata = '0;
  logic [PdataW-1:0]  prdata;
  logic               pready;

  // idle limits, switched between 0 and 10 so some stretches run flat out
  int in_gap_max = 10;
  int out_stall_max = 10;

  sched_scoreboard sb = new();

  always #6 clk_i = ~clk_i;

  adc_conversion_scheduler_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // --------------------------------------------------------------------------
  // request side: drive at the falling edge, accept at the rising edge
  // --------------------------------------------------------------------------
  task automatic send_request(in_t r);
    int gap;
    gap = $urandom_range(0, in_gap_max);
    @(negedge clk_i);
    // valid only drops when a gap is taken, so back-to-back requests keep it high
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid <= 1'b1;
    in_data <= r;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_request(r);
  endtask

  task automatic request_of(logic [OpW-1:0] op, logic [PinW-1:0] p,
                            logic [PeriodW-1:0] per, logic [SampleW-1:0] s);
    in_t r;
    r.op = op;
    r.pin = p;
    r.period = per;
    r.sample = s;
    send_request(r);
  endtask

  // wait until every predicted result is out, then let a long walk finish
  task automatic drain_and_settle();
    @(negedge clk_i);
    in_valid <= 1'b0;
    while (sb.awaited_results.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // register write: setup cycle, then access cycle
  task automatic write_pin_count(logic [PinCountW-1:0] v);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= PinCountAddr;
    pwdata <= PdataW'(v);
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.set_pin_limit(v);
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // random request, weighted toward well-formed traffic on valid pins
  function automatic in_t random_request(logic [PinCountW-1:0] limit);
    in_t r;
    int roll;
    int pick;
    r.pin = PinW'($urandom_range(0, 31));
    r.period = PeriodW'($urandom);
    r.sample = SampleW'($urandom_range(0, 1023));
    if ($urandom_range(0, 9) != 0) r.pin = PinW'($urandom_range(0, int'(limit) - 1));
    roll = $urandom_range(0, 99);
    if (roll < 12) begin
      r.op = OP_ADD;
      // short periods make wraps frequent; long and zero ones still appear
      pick = $urandom_range(0, 99);
      if (pick < 70) r.period = PeriodW'($urandom_range(1, 6));
      else if (pick < 85) r.period = PeriodW'($urandom_range(7, 40));
      else if (pick < 95) r.period = PeriodW'($urandom);
      else if (pick < 98) r.period = '0;
      else r.period = '1;
    end else if (roll < 18) begin
      r.op = OP_REMOVE;
    end else if (roll < 44) begin
      r.op = OP_REQUEST;
    end else if (roll < 70) begin
      r.op = OP_TICK;
    end else if (roll < 97) begin
      r.op = OP_COMPLETE;
    end else begin
      r.op = OpW'($urandom_range(int'(OpSpareLo), int'(OpSpareHi)));
    end
    return r;
  endfunction

  task automatic run_random(int count);
    in_t r;
    int done_items;
    done_items = 0;
    while (done_items < count) begin
      if (done_items % IdleSwitchEvery == 0) begin
        in_gap_max = $urandom_range(0, 2) == 0 ? 0 : 10;
        out_stall_max = $urandom_range(0, 2) == 0 ? 0 : 10;
      end
      r = random_request(sb.pin_limit);
      send_request(r);
      // spare op codes do nothing and do not count
      if (r.op <= OP_COMPLETE) done_items++;
    end
  endtask

  // --------------------------------------------------------------------------
  // result side: random stall per result, check at the accepting edge
  // --------------------------------------------------------------------------
  initial begin
    int stall;
    forever begin
      stall = $urandom_range(0, out_stall_max);
      if (stall > 0) begin
        @(negedge clk_i);
        out_ready <= 1'b0;
        repeat (stall - 1) @(negedge clk_i);
      end
      @(negedge clk_i);
      out_ready <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      sb.check_result(out_data_o);
    end
  end

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(negedge clk_i);

    write_pin_count(6'd25);

    // directed: start and queue, out-of-range pins, completions
    request_of(OP_REQUEST, 5'd0, 16'h0000, 10'h000);
    request_of(OP_REQUEST, 5'd24, 16'hFFFF, 10'h3FF);
    request_of(OP_REQUEST, 5'd25, 16'h0000, 10'h000);    // at pin_count: ignored
    request_of(OP_REQUEST, 5'd31, 16'h0000, 10'h000);
    request_of(OP_COMPLETE, 5'd0, 16'h0000, 10'h3FF);   // report, then start queued pin
    request_of(OP_COMPLETE, 5'd31, 16'hFFFF, 10'h000);  // report, goes idle
    request_of(OP_COMPLETE, 5'd0, 16'h0000, 10'h200);   // idle: no result
    request_of(OpSpareLo, 5'd31, 16'hFFFF, 10'h3FF);
    request_of(OpSpareHi, 5'd0, 16'h0000, 10'h000);

    // trigger table: zero period, pin out of range, then real entries
    request_of(OP_ADD, 5'd3, 16'h0000, 10'h000);
    request_of(OP_ADD, 5'd30, 16'd5, 10'h000);
    request_of(OP_ADD, 5'd3, 16'd1, 10'h000);
    request_of(OP_ADD, 5'd5, 16'd2, 10'h000);
    request_of(OP_ADD, 5'd3, 16'hFFFF, 10'h000);
    request_of(OP_TICK, 5'd0, 16'h0000, 10'h000);       // first wrap starts pin 3
    request_of(OP_TICK, 5'd0, 16'h0000, 10'h000);       // two wraps go to the ring
    request_of(OP_REMOVE, 5'd3, 16'h0000, 10'h000);     // drops both pin 3 entries

    // fill the table and try one more
    for (int i = 0; i < TrigSlots; i++)
      request_of(OP_ADD, PinW'(10 + i), 16'hFFFF, 10'h000);

    // fill the ring while busy; the last one is dropped
    for (int i = 0; i < QueueSlots - 2; i++)
      request_of(OP_REQUEST, PinW'(i + 1), 16'h0000, 10'h000);

    run_random(RandomPerPhase);

    // pin_count extremes, then a middle value, then the top again
    drain_and_settle();
    write_pin_count(6'd1);
    run_random(RandomPerPhase);

    drain_and_settle();
    write_pin_count(6'd32);
    run_random(RandomPerPhase);

    drain_and_settle();
    write_pin_count(PinCountW'($urandom_range(2, 31)));
    run_random(RandomPerPhase);

    drain_and_settle();
    write_pin_count(6'd32);
    run_random(RandomPerPhase);

    drain_and_settle();

    if (sb.errors == 0 && sb.awaited_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // watchdog, far beyond the slowest correct run
  initial begin
    #10_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
